>>> rtl/rasr_pkg.sv
`default_nettype none
package rasr_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned WidthDefault = 32;

  typedef enum logic [1:0] {
    MODE_REDUCE = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_SUB    = 2'd2,
    MODE_EQ     = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD_A,
    ST_RED_START,
    ST_RED_WAIT,
    ST_STORE_A,
    ST_LOAD_B,
    ST_STORE_B,
    ST_MUL,
    ST_SUM,
    ST_LOAD_R,
    ST_FINISH,
    ST_OUT
  } state_t;

  // reduction unit: gcd, then two divisions
  typedef enum logic [2:0] {
    RU_IDLE,
    RU_GCD,
    RU_DIVN,
    RU_DIVD,
    RU_DONE
  } ru_state_t;

  // operand select for the reduction unit
  typedef enum logic [1:0] {
    SRC_A,
    SRC_B,
    SRC_SUM
  } src_t;

  typedef struct packed {
    logic  capture;
    logic  load;
    src_t  src;
    logic  red_start;
    logic  store_a;
    logic  store_b;
    logic  mul;
    logic  sum;
    logic  finish;
    logic  out_take;
  } cmd_t;

  typedef struct packed {
    logic  red_done;
    mode_t mode;
  } sts_t;

endpackage
`default_nettype wire

>>> rtl/rasr_if.sv
`default_nettype none
interface rasr_in_if #(parameter int unsigned W = 32);
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic signed [W-1:0] a_num;
  logic signed [W-1:0] a_den;
  logic signed [W-1:0] b_num;
  logic signed [W-1:0] b_den;
  modport source (output valid, mode, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, mode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rasr_out_if #(parameter int unsigned W = 32);
  logic       valid;
  logic       ready;
  logic signed [W-1:0] res_num;
  logic signed [W-1:0] res_den;
  logic       equal;
  logic       overflow;
  modport source (output valid, res_num, res_den, equal, overflow, input ready);
  modport sink (input valid, res_num, res_den, equal, overflow, output ready);
endinterface
`default_nettype wire

>>> rtl/rasr_reduce.sv
`default_nettype none
// reduces |n|/|d| (n nonzero): binary gcd, then restoring division of both
module rasr_reduce #(
  parameter int unsigned MW = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [MW-1:0] n_in,
  input  wire logic [MW-1:0] d_in,
  output logic               done,
  output logic [MW-1:0]      n_out,
  output logic [MW-1:0]      d_out
);
  import rasr_pkg::*;

  localparam int unsigned CW = $clog2(MW + 1);

  ru_state_t state, state_next;
  logic [MW-1:0] x, y, g, n_keep, d_keep;
  logic [CW-1:0] shift, cnt;
  logic [MW-1:0] quo, rem;
  logic [MW:0]   trial;
  logic [MW-1:0] dividend;
  logic [MW-1:0] quo_step;

  assign done = (state == RU_DONE);
  assign trial = {rem, dividend[MW-1]} - {1'b0, g};
  assign quo_step = {quo[MW-2:0], !trial[MW]};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      RU_IDLE: if (start) state_next = RU_GCD;
      RU_GCD: begin
        if (y == '0 || x == '0) state_next = RU_DIVN;
      end
      RU_DIVN: if (cnt == CW'(MW - 1)) state_next = RU_DIVD;
      RU_DIVD: if (cnt == CW'(MW - 1)) state_next = RU_DONE;
      RU_DONE: state_next = RU_IDLE;
      default: state_next = RU_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= RU_IDLE;
    else     state <= state_next;
  end

  // gcd and division datapath
  always_ff @(posedge clk) begin
    case (state)
      RU_IDLE: begin
        x      <= n_in;
        y      <= d_in;
        n_keep <= n_in;
        d_keep <= d_in;
        shift  <= '0;
        cnt    <= '0;
      end
      RU_GCD: begin
        if (y == '0 || x == '0) begin
          g        <= (x | y) << shift;
          dividend <= n_keep;
          rem      <= '0;
          quo      <= '0;
          cnt      <= '0;
        end else if (!x[0] && !y[0]) begin
          x <= x >> 1; y <= y >> 1; shift <= shift + 1'b1;
        end else if (!x[0]) begin
          x <= x >> 1;
        end else if (!y[0]) begin
          y <= y >> 1;
        end else if (x >= y) begin
          x <= (x - y) >> 1;
        end else begin
          y <= (y - x) >> 1;
        end
      end
      RU_DIVN, RU_DIVD: begin
        if (cnt == CW'(MW - 1)) begin
          // last quotient bit, then reload for the next division
          cnt <= '0;
          rem <= '0;
          quo <= '0;
          if (state == RU_DIVN) begin
            n_out    <= quo_step;
            dividend <= d_keep;
          end else begin
            d_out <= quo_step;
          end
        end else begin
          if (!trial[MW]) rem <= trial[MW-1:0];
          else            rem <= {rem[MW-2:0], dividend[MW-1]};
          quo      <= quo_step;
          dividend <= dividend << 1;
          cnt      <= cnt + 1'b1;
        end
      end
      default: ;
    endcase
  end

  gcd_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == RU_GCD && n_keep != '0 && (x == '0 || y == '0)) |-> ((x | y) != '0))
    else $error("gcd of zero operands");
  div_after_gcd: assert property (@(posedge clk) disable iff (rst)
    (state == RU_DIVN && $past(state) != RU_DIVN) |-> $past(state) == RU_GCD)
    else $error("division entered out of order");
  done_one_cycle: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held");

endmodule
`default_nettype wire

>>> rtl/rasr_datapath.sv
`default_nettype none
module rasr_datapath #(
  parameter int unsigned WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire rasr_pkg::cmd_t   cmd,
  output rasr_pkg::sts_t        sts,
  rasr_in_if.sink               in_ch,
  output logic [rasr_pkg::DataW-1:0] o_num,
  output logic [rasr_pkg::DataW-1:0] o_den,
  output logic                  o_equal,
  output logic                  o_ovf
);
  import rasr_pkg::*;

  localparam int unsigned MW = 2 * WIDTH;

  mode_t mode;
  logic [WIDTH-1:0] an, ad, bn, bd;
  // sign and magnitude of fields
  logic an_s, ad_s, bn_s, bd_s;
  logic [WIDTH-1:0] an_m, ad_m, bn_m, bd_m;
  // reduced operands
  logic ra_s, rb_s;
  logic [WIDTH:0] ra_n, ra_d, rb_n, rb_d;
  logic [MW-1:0] p_m, q_m, dd;
  logic s_s;
  logic [MW-1:0] s_m;
  logic q_s;
  // reduction unit operands and result sign
  logic [MW-1:0] ru_n, ru_d, ru_no, ru_do;
  logic ru_neg, ru_zn, ru_zd;
  logic cur_neg, cur_zn;
  logic [MW-1:0] cur_n, cur_d;
  logic ru_done;
  logic [MW:0] diff;

  assign an_s = an[WIDTH-1];
  assign ad_s = ad[WIDTH-1];
  assign bn_s = bn[WIDTH-1];
  assign bd_s = bd[WIDTH-1];
  assign an_m = an_s ? -an : an;
  assign ad_m = ad_s ? -ad : ad;
  assign bn_m = bn_s ? -bn : bn;
  assign bd_m = bd_s ? -bd : bd;

  // operand select for reduction
  always_comb begin
    case (cmd.src)
      SRC_A:   begin
        cur_n = MW'(an_m); cur_d = MW'(ad_m);
        cur_neg = an_s ^ (ad_s && ad_m != '0);
      end
      SRC_B:   begin
        cur_n = MW'(bn_m); cur_d = MW'(bd_m);
        cur_neg = bn_s ^ (bd_s && bd_m != '0);
      end
      default: begin
        cur_n = s_m; cur_d = dd; cur_neg = s_s;
      end
    endcase
    cur_zn = (cur_n == '0);
  end

  rasr_reduce #(.MW(MW)) u_red (
    .clk(clk), .rst(rst), .start(cmd.red_start),
    .n_in(ru_n), .d_in(ru_d), .done(ru_done), .n_out(ru_no), .d_out(ru_do)
  );

  assign sts.red_done = ru_done;
  assign sts.mode = mode;
  assign diff = {1'b0, p_m} - {1'b0, q_m};

  always_ff @(posedge clk) begin
    // input capture
    if (cmd.capture) begin
      mode <= mode_t'(in_ch.mode);
      an <= in_ch.a_num; ad <= in_ch.a_den;
      bn <= in_ch.b_num; bd <= in_ch.b_den;
    end
    // latch reduction operands
    if (cmd.load) begin
      ru_n <= cur_n; ru_d <= cur_d; ru_neg <= cur_neg;
      ru_zn <= cur_zn; ru_zd <= (cur_d == '0);
    end
    if (cmd.store_a) begin
      ra_s <= ru_zn ? 1'b0 : ru_neg;
      ra_n <= ru_zn ? '0 : ru_no[WIDTH:0];
      ra_d <= ru_zn ? (WIDTH+1)'(1) : ru_do[WIDTH:0];
    end
    if (cmd.store_b) begin
      rb_s <= ru_zn ? 1'b0 : ru_neg;
      rb_n <= ru_zn ? '0 : ru_no[WIDTH:0];
      rb_d <= ru_zn ? (WIDTH+1)'(1) : ru_do[WIDTH:0];
    end
    // cross products, one each, registered
    if (cmd.mul) begin
      p_m <= MW'(ra_n * rb_d);
      q_m <= MW'(rb_n * ra_d);
      dd  <= MW'(ra_d * rb_d);
      q_s <= rb_s ^ (mode == MODE_SUB);
    end
    // signed-magnitude sum
    if (cmd.sum) begin
      if ((ra_s && p_m != '0) == (q_s && q_m != '0)) begin
        s_m <= p_m + q_m; s_s <= ra_s && p_m != '0;
      end else if (!diff[MW]) begin
        s_m <= diff[MW-1:0]; s_s <= ra_s && p_m != '0;
      end else begin
        s_m <= q_m - p_m; s_s <= q_s && q_m != '0;
      end
    end
    // final result with overflow
    if (cmd.finish) begin
      if (mode == MODE_EQ) begin
        o_num <= '0; o_den <= DataW'(1); o_ovf <= 1'b0;
        o_equal <= (an == bn) && (ad == bd);
      end else if (ru_zn) begin
        o_num <= '0; o_den <= DataW'(1); o_ovf <= 1'b0;
        o_equal <= 1'b0;
      end else begin
        o_num <= DataW'(signed'(ru_neg ? -ru_no[WIDTH-1:0] : ru_no[WIDTH-1:0]));
        o_den <= DataW'(signed'(ru_do[WIDTH-1:0]));
        o_ovf <= (ru_neg ? (ru_no > (MW'(1) << (WIDTH-1)))
                         : (ru_no > ((MW'(1) << (WIDTH-1)) - 1'b1)))
              || (ru_do > ((MW'(1) << (WIDTH-1)) - 1'b1));
        o_equal <= 1'b0;
      end
    end
  end

  unused_zd: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && mode != MODE_EQ && !ru_zn) |-> $past(ru_done) || $past(ru_done, 2))
    else $error("finish without reduction");
  store_a_nz: assert property (@(posedge clk) disable iff (rst)
    cmd.store_a |-> (ru_zn || ru_zd || ru_do != '0))
    else $error("zero denominator from reduction");
  in_ready_cap: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> in_ch.valid)
    else $error("capture without valid");

endmodule
`default_nettype wire

>>> rtl/rasr_ctrl.sv
`default_nettype none
module rasr_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire rasr_pkg::sts_t sts,
  output rasr_pkg::cmd_t      cmd
);
  import rasr_pkg::*;

  state_t state, state_next;
  // set once operand b has gone to the reduction unit
  logic second, second_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      second <= 1'b0;
    end else begin
      state <= state_next;
      second <= second_next;
    end
  end

  always_comb begin
    state_next = state;
    second_next = second;
    cmd = '0;
    cmd.src = SRC_A;
    in_ready = (state == ST_IDLE);
    out_valid = (state == ST_OUT);
    case (state)
      ST_IDLE: if (in_valid) begin
        cmd.capture = 1'b1;
        state_next = ST_LOAD_A;
      end
      ST_LOAD_A: begin
        cmd.load = 1'b1;
        cmd.src = SRC_A;
        second_next = 1'b0;
        state_next = (sts.mode == MODE_EQ) ? ST_FINISH : ST_RED_START;
      end
      ST_RED_START: begin
        cmd.red_start = 1'b1;
        state_next = ST_RED_WAIT;
      end
      ST_RED_WAIT: if (sts.red_done) begin
        if (sts.mode == MODE_REDUCE || second) state_next = ST_FINISH;
        else state_next = ST_STORE_A;
      end
      ST_STORE_A: begin
        cmd.store_a = 1'b1;
        state_next = ST_LOAD_B;
      end
      ST_LOAD_B: begin
        cmd.load = 1'b1;
        cmd.src = SRC_B;
        state_next = ST_STORE_B;
      end
      ST_STORE_B: begin
        // wait a pass through reduction for b
        if (!second) begin
          cmd.red_start = 1'b1;
          second_next = 1'b1;
        end else if (sts.red_done) begin
          cmd.store_b = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum = 1'b1;
        state_next = ST_LOAD_R;
      end
      ST_LOAD_R: begin
        cmd.load = 1'b1;
        cmd.src = SRC_SUM;
        state_next = ST_RED_START;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: if (out_ready) begin
        cmd.out_take = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output open together");
  out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped");
  take_then_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |=> in_ready)
    else $error("not idle after transfer");

endmodule
`default_nettype wire

>>> rtl/rational_add_sub_reduce_core.sv
// operation: reduce runs one reduction; add/sub runs three (operand a, operand b, then
// the sum); equality runs none; all set by the shared reduction unit (binary gcd one
// step per cycle, then two bit-serial divisions, of the numerator and the denominator)
// throughput: one item at a time; next input is accepted after the result transfer
// reset: synchronous active-high rst returns both state machines to idle
`default_nettype none
module rational_add_sub_reduce_core #(
  parameter int unsigned WIDTH = rasr_pkg::WidthDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  rasr_in_if.sink   in_ch,
  rasr_out_if.source out_ch
);
  import rasr_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic [DataW-1:0] o_num, o_den;
  logic o_equal, o_ovf;

  rasr_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts(sts), .cmd(cmd)
  );

  rasr_datapath #(.WIDTH(WIDTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .in_ch(in_ch),
    .o_num(o_num), .o_den(o_den), .o_equal(o_equal), .o_ovf(o_ovf)
  );

  assign out_ch.res_num  = o_num;
  assign out_ch.res_den  = o_den;
  assign out_ch.equal    = o_equal;
  assign out_ch.overflow = o_ovf;

endmodule
`default_nettype wire

>>> tb/sv/rasr_checker.sv
`default_nettype none
module rasr_checker (
  input  wire logic clk,
  input  wire logic rst,
  rasr_in_if        in_ch,
  rasr_out_if       out_ch,
  output int        fail_count,
  output int        pending
);
  import rasr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned W = DataW;
  localparam logic [63:0] SIGN_MAG = 64'd1 << (W - 1);
  localparam logic [63:0] FIELD_MASK = (64'd1 << W) - 64'd1;

  typedef struct {
    bit          neg;
    logic [63:0] mag;
  } smag_t;

  typedef struct {
    smag_t       n;
    logic [63:0] d;
  } frac_t;

  typedef struct {
    logic [W-1:0] num;
    logic [W-1:0] den;
    logic         equal;
    logic         overflow;
  } fraction_res_t;

  fraction_res_t fraction_q[$];

  // split a raw field into sign and magnitude
  function automatic smag_t to_smag(logic [W-1:0] v);
    smag_t r;
    r.neg = v[W-1];
    r.mag = v[W-1] ? ((~{32'd0, v} + 64'd1) & FIELD_MASK) : {32'd0, v};
    return r;
  endfunction

  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // divide out the gcd, fold the denominator sign into the numerator
  function automatic frac_t lowest_terms(smag_t n, smag_t d);
    frac_t r;
    logic [63:0] g;
    if (n.mag == 0) begin
      r.n.neg = 0;
      r.n.mag = 0;
      r.d = 1;
      return r;
    end
    g = gcd64(n.mag, d.mag);
    r.n.mag = n.mag / g;
    r.d = d.mag / g;
    r.n.neg = n.neg != (d.neg && d.mag != 0);
    return r;
  endfunction

  function automatic smag_t signed_sum(smag_t a, smag_t b);
    smag_t r;
    if (a.neg == b.neg) begin
      r.neg = a.neg;
      r.mag = a.mag + b.mag;
    end else if (a.mag >= b.mag) begin
      r.neg = a.neg;
      r.mag = a.mag - b.mag;
    end else begin
      r.neg = b.neg;
      r.mag = b.mag - a.mag;
    end
    if (r.mag == 0) r.neg = 0;
    return r;
  endfunction

  function automatic fraction_res_t compute_fraction(mode_t mode, logic [W-1:0] an,
                                                     logic [W-1:0] ad, logic [W-1:0] bn,
                                                     logic [W-1:0] bd);
    fraction_res_t e;
    frac_t ra, rb, r;
    smag_t p, q, dd;
    logic [63:0] sn;
    if (mode == MODE_EQ) begin
      e.num = 0;
      e.den = 1;
      e.equal = (an == bn) && (ad == bd);
      e.overflow = 0;
      return e;
    end
    if (mode == MODE_REDUCE) begin
      r = lowest_terms(to_smag(an), to_smag(ad));
    end else begin
      ra = lowest_terms(to_smag(an), to_smag(ad));
      rb = lowest_terms(to_smag(bn), to_smag(bd));
      p.mag = ra.n.mag * rb.d;
      p.neg = ra.n.neg && p.mag != 0;
      q.mag = rb.n.mag * ra.d;
      q.neg = rb.n.neg && q.mag != 0;
      if (mode == MODE_SUB && q.mag != 0) q.neg = !q.neg;
      dd.neg = 0;
      dd.mag = ra.d * rb.d;
      r = lowest_terms(signed_sum(p, q), dd);
    end
    e.overflow = (r.n.neg ? (r.n.mag > SIGN_MAG) : (r.n.mag > SIGN_MAG - 1))
                 || (r.d > SIGN_MAG - 1);
    sn = r.n.neg ? (64'd0 - r.n.mag) : r.n.mag;
    e.num = sn[W-1:0];
    e.den = r.d[W-1:0];
    e.equal = 0;
    return e;
  endfunction

  assign pending = fraction_q.size();

  // predict on every input transfer, compare on every output transfer
  always @(posedge clk) begin
    fraction_res_t exp_r;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        fraction_q.push_back(compute_fraction(mode_t'(in_ch.mode), in_ch.a_num,
                                              in_ch.a_den, in_ch.b_num, in_ch.b_den));
      if (out_ch.valid && out_ch.ready) begin
        if (fraction_q.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          exp_r = fraction_q.pop_front();
          if (out_ch.res_num !== exp_r.num || out_ch.res_den !== exp_r.den ||
              out_ch.equal !== exp_r.equal || out_ch.overflow !== exp_r.overflow)
            fail_count <= fail_count + 1;
          if (out_ch.res_num !== exp_r.num)
            $error("res_num expected %h actual %h", exp_r.num, out_ch.res_num);
          if (out_ch.res_den !== exp_r.den)
            $error("res_den expected %h actual %h", exp_r.den, out_ch.res_den);
          if (out_ch.equal !== exp_r.equal)
            $error("equal expected %b actual %b", exp_r.equal, out_ch.equal);
          if (out_ch.overflow !== exp_r.overflow)
            $error("overflow expected %b actual %b", exp_r.overflow, out_ch.overflow);
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> tb/sv/tb.sv
`default_nettype none
module tb;
  import rasr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned W = DataW;
  localparam int RANDOM_ITEMS = 1430;
  localparam int CYCLE_LIMIT = 4000000;
  localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};

  logic clk = 0;
  logic rst = 1;
  int   fail_count;
  int   pending;
  int   cycles = 0;
  bit   calm = 0;

  rasr_in_if  #(.W(W)) in_ch ();
  rasr_out_if #(.W(W)) out_ch ();

  rational_add_sub_reduce_core #(.WIDTH(W)) u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  rasr_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #1 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.mode = MODE_REDUCE;
    in_ch.a_num = 0;
    in_ch.a_den = 1;
    in_ch.b_num = 0;
    in_ch.b_den = 1;
    out_ch.ready = 0;
  end

  // result sink stalls at random outside calm stretches
  always @(posedge clk) begin
    out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 30);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // one input transfer, optional random idle first
  task automatic send_fraction(mode_t mode, logic [W-1:0] an, logic [W-1:0] ad,
                               logic [W-1:0] bn, logic [W-1:0] bd);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(99) < 30) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.mode <= mode;
    in_ch.a_num <= an;
    in_ch.a_den <= ad;
    in_ch.b_num <= bn;
    in_ch.b_den <= bd;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // field values biased toward extremes and shared factors
  function automatic logic [W-1:0] pick_field(int unsigned factor);
    case ($urandom_range(9))
      0: return 0;
      1: return 1;
      2: return {W{1'b1}};
      3: return MOST_NEG;
      4: return MOST_POS;
      5: return $urandom_range(0, 40) - 20;
      6: return factor * ($urandom_range(0, 2000) - 1000);
      7: return factor * $urandom_range(0, 1 << 20);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned f;
    logic [W-1:0] an, ad, bn, bd;
    mode_t m;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed corners: zero denominators, most negative, sign folding
    calm = 1;
    send_fraction(MODE_REDUCE, 0, 0, 0, 0);
    send_fraction(MODE_REDUCE, 5, 0, 0, 0);
    send_fraction(MODE_REDUCE, -5, 0, 0, 0);
    send_fraction(MODE_REDUCE, 0, -7, 0, 0);
    send_fraction(MODE_REDUCE, 6, -4, 0, 0);
    send_fraction(MODE_REDUCE, MOST_NEG, -1, 0, 0);
    send_fraction(MODE_REDUCE, MOST_NEG, 1, 0, 0);
    send_fraction(MODE_REDUCE, MOST_NEG, MOST_NEG, 0, 0);
    send_fraction(MODE_REDUCE, MOST_POS, MOST_NEG, 0, 0);
    send_fraction(MODE_REDUCE, -12, -18, 0, 0);
    send_fraction(MODE_ADD, MOST_POS, 1, MOST_POS, 1);
    send_fraction(MODE_ADD, MOST_NEG, 1, MOST_NEG, 1);
    send_fraction(MODE_ADD, 1, MOST_POS, 1, MOST_POS - 1);
    send_fraction(MODE_ADD, 1, 2, -1, 2);
    send_fraction(MODE_ADD, 3, 0, 1, 2);
    send_fraction(MODE_SUB, MOST_NEG, 1, MOST_NEG, 1);
    send_fraction(MODE_SUB, 0, 1, MOST_NEG, 1);
    send_fraction(MODE_SUB, 1, 3, 1, -6);
    send_fraction(MODE_SUB, -4, 0, 2, 0);
    send_fraction(MODE_EQ, 3, 4, 3, 4);
    send_fraction(MODE_EQ, 3, 4, 3, 5);
    send_fraction(MODE_EQ, MOST_NEG, MOST_POS, MOST_NEG, MOST_POS);
    send_fraction(MODE_EQ, -1, 1, 1, -1);
    calm = 0;

    // sender holds off until the block has drained
    in_ch.valid <= 0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);

    // random items, with one calm stretch in the middle
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= 600 && i < 700);
      f = $urandom_range(1, 3000);
      m = mode_t'($urandom_range(3));
      an = pick_field(f);
      ad = pick_field(f);
      bn = pick_field(f);
      bd = pick_field(f);
      if (m == MODE_EQ && $urandom_range(1)) begin
        bn = an;
        if ($urandom_range(1)) bd = ad;
      end
      send_fraction(m, an, ad, bn, bd);
    end
    in_ch.valid <= 0;
    calm = 0;

    // drain and settle
    @(posedge clk);
    wait (pending == 0);
    repeat (500) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
rtl/rasr_pkg.sv
rtl/rasr_if.sv
rtl/rasr_reduce.sv
rtl/rasr_datapath.sv
rtl/rasr_ctrl.sv
rtl/rational_add_sub_reduce_core.sv
tb/sv/rasr_checker.sv
tb/sv/tb.sv
